>>> rtl/core/trilinear_grid_sampler_macros.svh
// Assertion macros used by the checker file.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef TRILINEAR_GRID_SAMPLER_MACROS_SVH
`define TRILINEAR_GRID_SAMPLER_MACROS_SVH

// Consequent checked at the same edge as the antecedent (may open with a delay).
`define TGS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tgs_checker: property failed");

// Consequent checked at the edge after the antecedent.
`define TGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tgs_checker: property failed");

`endif

>>> rtl/core/tgs_pkg.sv
`timescale 1ns / 1ps
package tgs_pkg;

  localparam int DIM_X = 64;
  localparam int DIM_Y = 64;
  localparam int DIM_Z = 64;

  localparam int DIM_MAX   = (DIM_X > DIM_Y) ? ((DIM_X > DIM_Z) ? DIM_X : DIM_Z)
                                             : ((DIM_Y > DIM_Z) ? DIM_Y : DIM_Z);
  localparam int IDX_W     = $clog2(DIM_MAX);
  localparam int VOX_DEPTH = DIM_X * DIM_Y * DIM_Z;
  localparam int ADDR_W    = $clog2(VOX_DEPTH);

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic signed [15:0] voxel_t;
  typedef logic [16:0]       wgt_t;    // 0 .. 1.0 with 16 fraction bits
  typedef logic [8:0]        dim_t;

  localparam wgt_t HALF_Q16 = 17'd32768;

  localparam logic [31:0] CPU_RESET  = 32'h0001_0000;
  localparam logic [26:0] DIMS_RESET = {9'(DIM_Z), 9'(DIM_Y), 9'(DIM_X)};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_CPU_X    = 3'd3,
    CFG_CPU_Y    = 3'd4,
    CFG_CPU_Z    = 3'd5,
    CFG_DIMS     = 3'd6
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_CLAMP,
    ST_READ,
    ST_DRAIN,
    ST_LERP_Y0,
    ST_LERP_Y1,
    ST_LERP_X,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_lo;
    logic mul_hi;
    logic clamp;
  } axis_ctrl_t;

  function automatic dim_t dim_sat(dim_t d, dim_t dmax);
    if (d == 9'd0) return 9'd1;
    if (d > dmax) return dmax;
    return d;
  endfunction

  function automatic addr_t voxel_addr(idx_t x, idx_t y, idx_t z);
    logic [31:0] lin;
    lin = 32'(x) * 32'(DIM_Y * DIM_Z) + 32'(y) * 32'(DIM_Z) + 32'(z);
    return ADDR_W'(lin);
  endfunction

endpackage

>>> rtl/core/tgs_voxel_ram.sv
`timescale 1ns / 1ps
module tgs_voxel_ram import tgs_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  logic   we_i,
  input  addr_t  addr_i,
  input  voxel_t wdata_i,
  output voxel_t rdata_o
);

  voxel_t voxel_mem [VOX_DEPTH];
  voxel_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        voxel_mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= voxel_mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/tgs_axis.sv
`timescale 1ns / 1ps
module tgs_axis import tgs_pkg::*; (
  input  logic        clk_i,
  input  axis_ctrl_t  ctrl_i,
  input  logic [31:0] point_i,
  input  logic [31:0] origin_i,
  input  logic [31:0] cpu_i,
  input  dim_t        dim_i,
  output idx_t        lo_o,
  output idx_t        hi_o,
  output wgt_t        t_o
);

  logic signed [32:0] diff_q;
  logic signed [64:0] acc_q;
  logic [47:0]        prod_lo;
  logic signed [49:0] prod_hi;
  logic signed [32:0] ip;
  logic [15:0]        frac;
  logic               upper;
  logic signed [33:0] ip_w;
  logic signed [33:0] a_w;
  logic signed [33:0] b_w;
  wgt_t               t_d;
  idx_t               lo_q;
  idx_t               hi_q;
  wgt_t               t_q;

  function automatic idx_t clamp_idx(logic signed [33:0] v, dim_t dim);
    logic signed [33:0] dim_w;
    dim_w = $signed({25'd0, dim});
    if (v < 34'sd0) return '0;
    if (v >= dim_w) return IDX_W'(dim - 9'd1);
    return IDX_W'(v);
  endfunction

  // Signed 33 x unsigned 32 product in two halves of the difference.
  assign prod_lo = diff_q[15:0] * cpu_i;
  assign prod_hi = $signed(diff_q[32:16]) * $signed({1'b0, cpu_i});

  // Grid coordinate is the product floored to 16 fraction bits.
  assign ip    = acc_q[64:32];
  assign frac  = acc_q[31:16];
  assign ip_w  = 34'(ip);
  assign upper = {1'b0, frac} > HALF_Q16;
  assign t_d   = upper ? ({1'b0, frac} - HALF_Q16) : ({1'b0, frac} + HALF_Q16);
  assign a_w   = upper ? ip_w : (ip_w - 34'sd1);
  assign b_w   = upper ? (ip_w + 34'sd1) : ip_w;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      diff_q <= $signed({point_i[31], point_i}) - $signed({origin_i[31], origin_i});
    end
    if (ctrl_i.mul_lo) begin
      acc_q <= $signed({17'd0, prod_lo});
    end else if (ctrl_i.mul_hi) begin
      acc_q <= acc_q + (65'(prod_hi) <<< 16);
    end
    if (ctrl_i.clamp) begin
      lo_q <= clamp_idx(a_w, dim_i);
      hi_q <= clamp_idx(b_w, dim_i);
      t_q  <= t_d;
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;
  assign t_o  = t_q;

endmodule

>>> rtl/core/tgs_lerp.sv
`timescale 1ns / 1ps
module tgs_lerp import tgs_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  voxel_t a_i,
  input  voxel_t b_i,
  input  wgt_t   t_i,
  output voxel_t y_o
);

  logic signed [16:0] diff;
  logic signed [34:0] prod;
  logic signed [18:0] step;
  logic signed [18:0] sum;
  voxel_t             y_q;

  // a + floor((b - a) * t / 2^16) equals the weighted sum floored
  assign diff = $signed({b_i[15], b_i}) - $signed({a_i[15], a_i});
  assign prod = diff * $signed({1'b0, t_i});
  assign step = prod[34:16];
  assign sum  = step + 19'(a_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      y_q <= sum[15:0];
    end
  end

  assign y_o = y_q;

endmodule

>>> rtl/core/trilinear_grid_sampler.sv
`timescale 1ns / 1ps
// Trilinear sampler over a 3D grid of signed 16-bit voxels.
// Input stream: s_axis_tuser selects the command (0 write voxel, 1 query).
//   A write beat stores one voxel and gives no output beat;
//   writes outside the grid are dropped. Writes can go back to back.
// A query maps each axis point to grid units, reads the eight corner voxels
//   from the single-port voxel RAM one per cycle, lerps along z, y, then x.
//   The result beat is then loaded into the output register; s_axis_tready
//   is low from the query beat until the query ends, so the next beat is
//   taken only after it; the eight RAM reads and shared lerp unit run in turn.
// Output stream: m_axis_tdata carries the sample. The output register holds
//   the beat while m_axis_tready is low; a query that finishes then waits
//   in its last step until the register frees, and input stays blocked.
// Config channel: cfg_index_i picks the register, always ready; write only
//   while no query is in flight.
// Reset: config returns to origin 0, 1.0 cells per unit, 64 cells per axis.
//   The voxel RAM is not cleared; read only voxels that have been written.
module trilinear_grid_sampler import tgs_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] cell_x, [15:8] cell_y, [23:16] cell_z, [39:24] write_value,
  // [71:40] point_x, [103:72] point_y, [135:104] point_z
  input  logic [135:0] s_axis_tdata,
  // [0] cmd
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] sample_value
  output logic [15:0]  m_axis_tdata,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  logic [31:0] origin_x_q, origin_y_q, origin_z_q;
  logic [31:0] cpu_x_q, cpu_y_q, cpu_z_q;
  logic [26:0] dims_q;

  state_e     state_q, state_d;
  logic [2:0] rd_cnt_q, rd_cnt_d;

  logic [7:0]  cell_x, cell_y, cell_z;
  voxel_t      write_value;
  logic [31:0] point_x, point_y, point_z;
  logic        in_range;
  logic        in_ready;

  dim_t dim_x, dim_y, dim_z;
  axis_ctrl_t axis_ctrl;
  idx_t lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
  wgt_t tx, ty, tz;
  idx_t corner_x, corner_y, corner_z;

  logic   mem_en, mem_we;
  addr_t  mem_addr;
  voxel_t mem_rdata;

  logic       rvld_q;
  logic [2:0] ridx_q;
  voxel_t     even_q;
  voxel_t     zy_q [5];

  logic       lerp_en, lerp_store;
  voxel_t     lerp_a, lerp_b, lerp_y;
  wgt_t       lerp_t;
  logic [2:0] lerp_dst;
  logic       lerp_wr_q;
  logic [2:0] lerp_dst_q;

  logic   out_load;
  logic   out_vld_q;
  voxel_t out_data_q;

  assign cell_x      = s_axis_tdata[7:0];
  assign cell_y      = s_axis_tdata[15:8];
  assign cell_z      = s_axis_tdata[23:16];
  assign write_value = s_axis_tdata[39:24];
  assign point_x     = s_axis_tdata[71:40];
  assign point_y     = s_axis_tdata[103:72];
  assign point_z     = s_axis_tdata[135:104];

  assign in_range = (32'(cell_x) < 32'(DIM_X)) && (32'(cell_y) < 32'(DIM_Y)) &&
                    (32'(cell_z) < 32'(DIM_Z));

  assign dim_x = dim_sat(dims_q[8:0], 9'(DIM_X));
  assign dim_y = dim_sat(dims_q[17:9], 9'(DIM_Y));
  assign dim_z = dim_sat(dims_q[26:18], 9'(DIM_Z));

  // Config registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
      cpu_x_q    <= CPU_RESET;
      cpu_y_q    <= CPU_RESET;
      cpu_z_q    <= CPU_RESET;
      dims_q     <= DIMS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X: origin_x_q <= cfg_data_i;
        CFG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        CFG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        CFG_CPU_X:    cpu_x_q    <= cfg_data_i;
        CFG_CPU_Y:    cpu_y_q    <= cfg_data_i;
        CFG_CPU_Z:    cpu_z_q    <= cfg_data_i;
        CFG_DIMS:     dims_q     <= cfg_data_i[26:0];
        default: ;
      endcase
    end
  end

  tgs_axis u_axis_x (
    .clk_i    (clk_i),
    .ctrl_i   (axis_ctrl),
    .point_i  (point_x),
    .origin_i (origin_x_q),
    .cpu_i    (cpu_x_q),
    .dim_i    (dim_x),
    .lo_o     (lo_x),
    .hi_o     (hi_x),
    .t_o      (tx)
  );

  tgs_axis u_axis_y (
    .clk_i    (clk_i),
    .ctrl_i   (axis_ctrl),
    .point_i  (point_y),
    .origin_i (origin_y_q),
    .cpu_i    (cpu_y_q),
    .dim_i    (dim_y),
    .lo_o     (lo_y),
    .hi_o     (hi_y),
    .t_o      (ty)
  );

  tgs_axis u_axis_z (
    .clk_i    (clk_i),
    .ctrl_i   (axis_ctrl),
    .point_i  (point_z),
    .origin_i (origin_z_q),
    .cpu_i    (cpu_z_q),
    .dim_i    (dim_z),
    .lo_o     (lo_z),
    .hi_o     (hi_z),
    .t_o      (tz)
  );

  // Corner order: bit 2 picks x, bit 1 picks y, bit 0 picks z
  assign corner_x = rd_cnt_q[2] ? hi_x : lo_x;
  assign corner_y = rd_cnt_q[1] ? hi_y : lo_y;
  assign corner_z = rd_cnt_q[0] ? hi_z : lo_z;

  tgs_voxel_ram u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (write_value),
    .rdata_o (mem_rdata)
  );

  tgs_lerp u_lerp (
    .clk_i (clk_i),
    .en_i  (lerp_en),
    .a_i   (lerp_a),
    .b_i   (lerp_b),
    .t_i   (lerp_t),
    .y_o   (lerp_y)
  );

  // Next state
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid && (s_axis_tuser == CMD_QUERY)) state_d = ST_MUL_LO;
      end
      ST_MUL_LO:  state_d = ST_MUL_HI;
      ST_MUL_HI:  state_d = ST_CLAMP;
      ST_CLAMP:   state_d = ST_READ;
      ST_READ: begin
        rd_cnt_d = rd_cnt_q + 3'd1;
        if (rd_cnt_q == 3'd7) state_d = ST_DRAIN;
      end
      ST_DRAIN:   state_d = ST_LERP_Y0;
      ST_LERP_Y0: state_d = ST_LERP_Y1;
      ST_LERP_Y1: state_d = ST_LERP_X;
      ST_LERP_X:  state_d = ST_FINISH;
      ST_FINISH: begin
        if (!out_vld_q || m_axis_tready) state_d = ST_IDLE;
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    axis_ctrl  = '0;
    mem_en     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = voxel_addr(corner_x, corner_y, corner_z);
    lerp_en    = 1'b0;
    lerp_store = 1'b0;
    lerp_a     = even_q;
    lerp_b     = mem_rdata;
    lerp_t     = tz;
    lerp_dst   = {1'b0, ridx_q[2:1]};
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready       = 1'b1;
        axis_ctrl.load = s_axis_tvalid && (s_axis_tuser == CMD_QUERY);
        mem_en         = s_axis_tvalid && (s_axis_tuser == CMD_WRITE) && in_range;
        mem_we         = 1'b1;
        mem_addr       = voxel_addr(IDX_W'(cell_x), IDX_W'(cell_y), IDX_W'(cell_z));
      end
      ST_MUL_LO: axis_ctrl.mul_lo = 1'b1;
      ST_MUL_HI: axis_ctrl.mul_hi = 1'b1;
      ST_CLAMP:  axis_ctrl.clamp  = 1'b1;
      ST_READ, ST_DRAIN: begin
        mem_en = (state_q == ST_READ);
        // Lerp along z as the second voxel of each pair comes back
        lerp_en    = rvld_q && ridx_q[0];
        lerp_store = 1'b1;
      end
      ST_LERP_Y0: begin
        lerp_en    = 1'b1;
        lerp_store = 1'b1;
        lerp_a     = zy_q[0];
        lerp_b     = zy_q[1];
        lerp_t     = ty;
        lerp_dst   = 3'd4;
      end
      ST_LERP_Y1: begin
        lerp_en = 1'b1;
        lerp_a  = zy_q[2];
        lerp_b  = zy_q[3];
        lerp_t  = ty;
      end
      ST_LERP_X: begin
        // Second y result is still in the lerp output register
        lerp_en = 1'b1;
        lerp_a  = zy_q[4];
        lerp_b  = lerp_y;
        lerp_t  = tx;
      end
      ST_FINISH: out_load = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_cnt_q  <= '0;
      rvld_q    <= 1'b0;
      lerp_wr_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_cnt_q  <= rd_cnt_d;
      rvld_q    <= (state_q == ST_READ);
      lerp_wr_q <= lerp_en && lerp_store;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= rd_cnt_q;
    lerp_dst_q <= lerp_dst;
    if (rvld_q && !ridx_q[0]) begin
      even_q <= mem_rdata;
    end
    if (lerp_wr_q) begin
      zy_q[lerp_dst_q] <= lerp_y;
    end
    if (out_load) begin
      out_data_q <= lerp_y;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> rtl/core/tgs_checker.sv
`timescale 1ns / 1ps
`include "trilinear_grid_sampler_macros.svh"
module tgs_checker import tgs_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         s_axis_tuser,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [15:0]  m_axis_tdata
);

  logic query_beat;
  logic write_beat;

  assign query_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_QUERY);
  assign write_beat = s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_WRITE);

  `TGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  `TGS_ASSERT_NEXT(a_query_busy, query_beat, !s_axis_tready)
  `TGS_ASSERT_SAME(a_query_span, query_beat, ##15 !s_axis_tready)
  `TGS_ASSERT_NEXT(a_write_quiet, write_beat, !$rose(m_axis_tvalid))

endmodule

bind trilinear_grid_sampler tgs_checker u_tgs_checker (.*);

>>> verif/tb_trilinear_grid_sampler.sv
`timescale 1ns / 1ps
module tb_trilinear_grid_sampler;
  import tgs_pkg::*;

  localparam int          CYCLE_LIMIT   = 500000;
  localparam int          SETTLE_CYCLES = 40;
  localparam longint      ONE_Q16       = 65536;
  localparam logic [2:0]  CFG_SPARE     = 3'd7;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic         s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i;
  logic [31:0]  cfg_data_i;

  // Predicted grid contents; an entry exists only once it has been written.
  voxel_t       voxel_mem [int unsigned];
  logic [31:0]  org_x, org_y, org_z;
  logic [31:0]  cpu_x, cpu_y, cpu_z;
  logic [26:0]  dims_cfg;
  voxel_t       expected_samples [$];

  int unsigned  mismatches  = 0;
  int unsigned  cycle_count = 0;
  int unsigned  sink_hold   = 0;
  bit           src_gaps_on;
  bit           sink_gaps_on;

  trilinear_grid_sampler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("trilinear_grid_sampler regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic int axis_cells(int shift, int dmax);
    int d;
    d = int'((dims_cfg >> shift) & 27'h1FF);
    if (d == 0) d = 1;
    if (d > dmax) d = dmax;
    return d;
  endfunction

  // Scale one axis into grid units, pick the two cell-centered neighbors.
  function automatic void axis_split(input logic [31:0] pt, input logic [31:0] org,
                                     input logic [31:0] cpu, input int cells,
                                     output int lo, output int hi, output wgt_t wt);
    longint          diff, q, ip, f, a, b;
    longint unsigned mag;
    diff = longint'($signed(pt)) - longint'($signed(org));
    mag  = (diff < 0) ? -diff : diff;
    mag  = mag * {32'd0, cpu};
    // keep floor semantics on the negative side
    if (diff < 0) q = -longint'((mag + 64'hFFFF) >> 16);
    else          q = longint'(mag >> 16);
    ip = q >>> 16;
    f  = q & 64'hFFFF;
    if (f > longint'(HALF_Q16)) begin
      a  = ip;
      b  = ip + 1;
      wt = wgt_t'(f - longint'(HALF_Q16));
    end else begin
      a  = ip - 1;
      b  = ip;
      wt = wgt_t'(f + longint'(HALF_Q16));
    end
    lo = (a < 0) ? 0 : (a >= cells) ? cells - 1 : int'(a);
    hi = (b < 0) ? 0 : (b >= cells) ? cells - 1 : int'(b);
  endfunction

  function automatic voxel_t lerp_q16(voxel_t a, voxel_t b, wgt_t wt);
    longint acc;
    acc = longint'(a) * (ONE_Q16 - longint'(wt)) + longint'(b) * longint'(wt);
    return voxel_t'(acc >>> 16);
  endfunction

  function automatic int unsigned cell_index(int x, int y, int z);
    return int'((x * DIM_Y + y) * DIM_Z + z);
  endfunction

  // known drops to 0 when any corner was never written
  function automatic voxel_t interp_sample(input logic [31:0] px, input logic [31:0] py,
                                           input logic [31:0] pz, output bit known);
    int          x0, x1, y0, y1, z0, z1;
    wgt_t        tx, ty, tz;
    int unsigned k;
    voxel_t      c [8];
    voxel_t      v00, v01, v10, v11, w0, w1;
    axis_split(px, org_x, cpu_x, axis_cells(0, DIM_X), x0, x1, tx);
    axis_split(py, org_y, cpu_y, axis_cells(9, DIM_Y), y0, y1, ty);
    axis_split(pz, org_z, cpu_z, axis_cells(18, DIM_Z), z0, z1, tz);
    known = 1'b1;
    for (int i = 0; i < 8; i++) begin
      k = cell_index(i[2] ? x1 : x0, i[1] ? y1 : y0, i[0] ? z1 : z0);
      if (voxel_mem.exists(k)) begin
        c[i] = voxel_mem[k];
      end else begin
        c[i]  = '0;
        known = 1'b0;
      end
    end
    v00 = lerp_q16(c[0], c[1], tz);
    v01 = lerp_q16(c[2], c[3], tz);
    v10 = lerp_q16(c[4], c[5], tz);
    v11 = lerp_q16(c[6], c[7], tz);
    w0  = lerp_q16(v00, v01, ty);
    w1  = lerp_q16(v10, v11, ty);
    return lerp_q16(w0, w1, tx);
  endfunction

  // ----------------------------------------------------------------- stimulus

  // Called at a clock edge; returns at the edge where the beat was taken.
  task automatic send_beat(cmd_e cmd, logic [135:0] payload);
    int unsigned gap;
    bit          known;
    gap = src_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= payload;
    do @(posedge clk_i); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      // drop writes outside the grid
      if (payload[7:0] < DIM_X && payload[15:8] < DIM_Y && payload[23:16] < DIM_Z)
        voxel_mem[cell_index(payload[7:0], payload[15:8], payload[23:16])] = payload[39:24];
    end else begin
      expected_samples.push_back(
        interp_sample(payload[71:40], payload[103:72], payload[135:104], known));
    end
  endtask

  task automatic send_write(logic [7:0] x, logic [7:0] y, logic [7:0] z, voxel_t value);
    send_beat(CMD_WRITE, {32'($urandom()), 32'($urandom()), 32'($urandom()),
                          value, z, y, x});
  endtask

  task automatic send_query(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_beat(CMD_QUERY, {pz, py, px, 16'($urandom()), 8'($urandom()),
                          8'($urandom()), 8'($urandom())});
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] org, logic [31:0] cpu, int cells);
    longint      g;
    int          span;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    span = (cells > 8) ? 8 : cells;
    if (mode == 0 || cpu == 0) return $urandom();
    if (mode == 1) return org + $urandom_range(0, 2) - 1;
    // land on or next to the half-cell boundary, or else at random over the span
    if (mode < 4) g = ONE_Q16 * longint'($urandom_range(0, span)) + 32767
                      + longint'($urandom_range(0, 2));
    else          g = longint'($urandom_range(0, (span + 2) * 65536)) - ONE_Q16;
    return org + 32'(g * ONE_Q16 / longint'(cpu));
  endfunction

  // Retry until all eight corners are written; fall back to the origin, which
  // always reads cell 0.
  task automatic send_random_query();
    logic [31:0] px, py, pz;
    bit          known;
    voxel_t      probe;
    known = 1'b0;
    for (int n = 0; n < 24 && !known; n++) begin
      px    = pick_coord(org_x, cpu_x, axis_cells(0, DIM_X));
      py    = pick_coord(org_y, cpu_y, axis_cells(9, DIM_Y));
      pz    = pick_coord(org_z, cpu_z, axis_cells(18, DIM_Z));
      probe = interp_sample(px, py, pz, known);
    end
    if (!known) begin
      px = org_x;
      py = org_y;
      pz = org_z;
    end
    send_query(px, py, pz);
  endtask

  task automatic send_random_write();
    if ($urandom_range(0, 6) == 0)
      send_write(8'($urandom()), 8'($urandom()), 8'($urandom()), 16'($urandom()));
    else
      send_write(8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 16'($urandom()));
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ORIGIN_X: org_x = value;
      CFG_ORIGIN_Y: org_y = value;
      CFG_ORIGIN_Z: org_z = value;
      CFG_CPU_X:    cpu_x = value;
      CFG_CPU_Y:    cpu_y = value;
      CFG_CPU_Z:    cpu_z = value;
      CFG_DIMS:     dims_cfg = value[26:0];
      default:      ;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                                logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                                logic [26:0] dims);
    cfg_write(CFG_ORIGIN_X, ox);
    cfg_write(CFG_ORIGIN_Y, oy);
    cfg_write(CFG_ORIGIN_Z, oz);
    cfg_write(CFG_CPU_X, cx);
    cfg_write(CFG_CPU_Y, cy);
    cfg_write(CFG_CPU_Z, cz);
    cfg_write(CFG_DIMS, 32'(dims));
    cfg_valid_i <= 1'b0;
  endtask

  // Drop input valid, wait for every sample, then let the pipeline settle.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [31:0] draw_origin();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return $urandom();
      default: return 32'($urandom_range(0, 32'h80000)) - 32'h40000;
    endcase
  endfunction

  function automatic logic [31:0] draw_rate();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'($urandom_range(1, 255));
      2, 3:    return CPU_RESET;
      4:       return $urandom();
      default: return 32'($urandom_range(32'h4000, 32'h40000));
    endcase
  endfunction

  function automatic logic [8:0] draw_cells();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 9'($urandom());
      2:       return 9'($urandom_range(5, 8));
      default: return 9'($urandom_range(1, 4));
    endcase
  endfunction

  // -------------------------------------------------------------------- tests

  task automatic test_preload();
    for (int x = 0; x < 4; x++)
      for (int y = 0; y < 4; y++)
        for (int z = 0; z < 4; z++)
          send_write(8'(x), 8'(y), 8'(z), 16'($urandom()));
    // far corners of the full grid, hit when points clamp at the top
    for (int i = 0; i < 8; i++)
      send_write(i[2] ? 8'd63 : 8'd0, i[1] ? 8'd63 : 8'd0, i[0] ? 8'd63 : 8'd0,
                 16'($urandom()));
  endtask

  task automatic test_write_edges();
    send_write(8'd0, 8'd0, 8'd0, 16'sh8000);
    send_write(8'd0, 8'd0, 8'd1, 16'sh7FFF);
    send_write(8'd1, 8'd1, 8'd1, 16'sh7FFF);
    send_write(8'd2, 8'd1, 8'd1, 16'sh8000);
    // out of the grid: ignored
    send_write(8'd64, 8'd0, 8'd0, 16'sh1234);
    send_write(8'd0, 8'd64, 8'd0, 16'sh1234);
    send_write(8'd0, 8'd0, 8'd64, 16'sh1234);
    send_write(8'd255, 8'd255, 8'd255, 16'shFFFF);
    send_write(8'd128, 8'd1, 8'd1, 16'sh0F0F);
  endtask

  task automatic test_query_edges();
    send_query(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_query(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    send_query(32'h0000_8001, 32'h0000_7FFF, 32'h0000_8001);
    send_query(32'h0001_8000, 32'h0001_4000, 32'h0002_C000);
    send_query(32'h0003_8000, 32'h0003_8000, 32'h0003_8000);
    send_query(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_query(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_query(32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000);
    send_query(32'hFFFF_0000, 32'hFFFF_B334, 32'h0000_C000);
    send_query(32'h0001_0000, 32'h0000_0001, 32'h0001_FFFF);
    send_query(32'h0000_C000, 32'h0001_C000, 32'h0000_4000);
  endtask

  task automatic test_config_extremes();
    quiesce();
    apply_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 27'h7FF_FFFF);
    repeat (20) send_random_query();
    quiesce();
    cfg_write(CFG_SPARE, $urandom());
    apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0, '0, '0);
    repeat (10) send_random_query();
    quiesce();
    apply_settings('0, '0, '0, 32'd1, 32'd1, 32'd1, {9'd3, 9'd1, 9'd4});
    repeat (10) send_random_query();
    repeat (5) send_random_write();
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      quiesce();
      apply_settings(draw_origin(), draw_origin(), draw_origin(),
                     draw_rate(), draw_rate(), draw_rate(),
                     {draw_cells(), draw_cells(), draw_cells()});
      src_gaps_on  = (phase % 3) != 0;
      sink_gaps_on = (phase % 2) != 0;
      repeat (125) begin
        if ($urandom_range(0, 99) < 35) send_random_write();
        else                            send_random_query();
      end
    end
  endtask

  // Stall the output long enough that queries back up into the input.
  task automatic test_output_backpressure();
    quiesce();
    apply_settings('0, '0, '0, CPU_RESET, CPU_RESET, CPU_RESET, {9'd4, 9'd4, 9'd4});
    src_gaps_on = 1'b0;
    sink_hold   = 400;
    repeat (12) send_random_query();
    src_gaps_on = 1'b1;
  endtask

  // ------------------------------------------------------------- sink / check

  initial begin : sink_ready
    int unsigned wait_left;
    wait_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        wait_left = sink_gaps_on ? $urandom_range(0, 14) : 0;
      if (sink_hold != 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (wait_left != 0) begin
        wait_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : sample_check
    voxel_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: sample_value expected none, actual %0d", $time,
                 $signed(m_axis_tdata));
        mismatches++;
      end else begin
        want = expected_samples.pop_front();
        if (m_axis_tdata !== want) begin
          $display("%0t: sample_value expected %0d, actual %0d", $time, want,
                   $signed(m_axis_tdata));
          mismatches++;
        end
      end
    end
  end

  initial begin
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_WRITE;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    rst_ni        <= 1'b0;
    org_x         = '0;
    org_y         = '0;
    org_z         = '0;
    cpu_x         = CPU_RESET;
    cpu_y         = CPU_RESET;
    cpu_z         = CPU_RESET;
    dims_cfg      = DIMS_RESET;
    src_gaps_on   = 1'b1;
    sink_gaps_on  = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_preload();
    test_write_edges();
    test_query_edges();
    test_config_extremes();
    test_random_traffic();
    test_output_backpressure();
    quiesce();

    if (mismatches == 0 && expected_samples.size() == 0)
      $display("trilinear_grid_sampler regression: pass");
    else
      $display("trilinear_grid_sampler regression: fail");
    $finish;
  end

endmodule
